@@ src/contour_flux_integrator_defines.svh @@
// ----------------------------------------------------------------------------
// Contour flux integrator assertion macros
// Concurrent assertion wrappers on clk with rst as disable; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CONTOUR_FLUX_INTEGRATOR_DEFINES_SVH
`define CONTOUR_FLUX_INTEGRATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CFI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("contour flux integrator assertion failed");
`define CFI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("contour flux integrator assertion failed");
`else
`define CFI_ASSERT(lbl, prop)
`define CFI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/cfi_pkg.sv @@
// ----------------------------------------------------------------------------
// Contour flux integrator package
// Shared constants, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package cfi_pkg;

  localparam int TABLE_DEPTH_DEF = 32768;

  // field and internal widths
  localparam int TVAL_W     = 40;
  localparam int FLUX_W     = 48;
  localparam int ADDR_W     = 19;
  localparam int DIV_QB     = 29;
  localparam int REM_W      = 30;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHI   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THETA = 1'b1;

  localparam logic [7:0] PHI_RESET   = 8'd72;
  localparam logic [8:0] THETA_RESET = 9'd360;
  localparam logic [7:0] PC_MIN = 8'd4;
  localparam logic [7:0] PC_MAX = 8'd254;
  localparam logic [8:0] TC_MIN = 9'd4;
  localparam logic [8:0] TC_MAX = 9'd510;

  localparam logic signed [FLUX_W-1:0] FLUX_MAX = {1'b0, {(FLUX_W-1){1'b1}}};
  localparam logic signed [FLUX_W-1:0] FLUX_MIN = {1'b1, {(FLUX_W-1){1'b0}}};

  // datapath operations
  localparam logic [4:0] OP_NONE  = 5'd0;
  localparam logic [4:0] OP_TAKE  = 5'd1;
  localparam logic [4:0] OP_GRID  = 5'd2;
  localparam logic [4:0] OP_SEG   = 5'd3;
  localparam logic [4:0] OP_SEG2  = 5'd4;
  localparam logic [4:0] OP_PIECE = 5'd5;
  localparam logic [4:0] OP_MUL   = 5'd6;
  localparam logic [4:0] OP_DIVI  = 5'd7;
  localparam logic [4:0] OP_DIV   = 5'd8;
  localparam logic [4:0] OP_MID   = 5'd9;
  localparam logic [4:0] OP_ADDR  = 5'd10;
  localparam logic [4:0] OP_MOD   = 5'd11;
  localparam logic [4:0] OP_RD0   = 5'd12;
  localparam logic [4:0] OP_RD1   = 5'd13;
  localparam logic [4:0] OP_RD2   = 5'd14;
  localparam logic [4:0] OP_SAMP  = 5'd15;
  localparam logic [4:0] OP_SAMP2 = 5'd16;
  localparam logic [4:0] OP_CON   = 5'd17;
  localparam logic [4:0] OP_ACC   = 5'd18;
  localparam logic [4:0] OP_UPD   = 5'd19;
  localparam logic [4:0] OP_FIN   = 5'd20;
  localparam logic [4:0] OP_OUT   = 5'd21;

  typedef struct packed {
    logic [4:0] op;
  } cfi_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic skip;
    logic last_piece;
    logic div_done;
    logic mod_done;
    logic last_pt;
  } cfi_stat_t;

endpackage

@@ src/cfi_ctrl.sv @@
// ----------------------------------------------------------------------------
// Contour flux integrator controller
// Sequences table loads, segment walking and result delivery.
// ----------------------------------------------------------------------------
`include "contour_flux_integrator_defines.svh"
module cfi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_type,
  output logic                req_stall,
  output logic                res_valid,
  input  logic                res_stall,
  output cfi_pkg::cfi_cmd_t   cmd,
  input  cfi_pkg::cfi_stat_t  st
);
  import cfi_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_GRID  = 5'd1;
  localparam logic [4:0] S_SEG   = 5'd2;
  localparam logic [4:0] S_SEG2  = 5'd3;
  localparam logic [4:0] S_PIECE = 5'd4;
  localparam logic [4:0] S_MUL   = 5'd5;
  localparam logic [4:0] S_DIVI  = 5'd6;
  localparam logic [4:0] S_DIV   = 5'd7;
  localparam logic [4:0] S_MID   = 5'd8;
  localparam logic [4:0] S_ADDR  = 5'd9;
  localparam logic [4:0] S_MOD   = 5'd10;
  localparam logic [4:0] S_RD0   = 5'd11;
  localparam logic [4:0] S_RD1   = 5'd12;
  localparam logic [4:0] S_RD2   = 5'd13;
  localparam logic [4:0] S_SAMP  = 5'd14;
  localparam logic [4:0] S_SAMP2 = 5'd15;
  localparam logic [4:0] S_CON   = 5'd16;
  localparam logic [4:0] S_ACC   = 5'd17;
  localparam logic [4:0] S_UPD   = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       slot_free;
  logic       accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign slot_free = !res_valid || !res_stall;

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = OP_TAKE;
          if (req_type) state_next = S_GRID;
        end
      end
      S_GRID: begin
        cmd.op     = OP_GRID;
        state_next = st.have_prev ? S_SEG : S_UPD;
      end
      S_SEG: begin
        cmd.op     = OP_SEG;
        state_next = S_SEG2;
      end
      S_SEG2: begin
        cmd.op     = OP_SEG2;
        state_next = st.skip ? S_UPD : S_PIECE;
      end
      S_PIECE: begin
        cmd.op     = OP_PIECE;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.op     = OP_DIVI;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (st.div_done) state_next = S_MID;
      end
      S_MID: begin
        cmd.op     = OP_MID;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.op     = OP_ADDR;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (st.mod_done) state_next = S_RD0;
      end
      S_RD0: begin
        cmd.op     = OP_RD0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.op     = OP_RD1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.op     = OP_RD2;
        state_next = S_SAMP;
      end
      S_SAMP: begin
        cmd.op     = OP_SAMP;
        state_next = S_SAMP2;
      end
      S_SAMP2: begin
        cmd.op     = OP_SAMP2;
        state_next = S_CON;
      end
      S_CON: begin
        cmd.op     = OP_CON;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = st.last_piece ? S_UPD : S_PIECE;
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = st.last_pt ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && slot_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  `CFI_ASSERT(a_res_from_out, $rose(res_valid) |-> $past(state) == S_OUT)
  `CFI_ASSERT_NEXT(a_point_to_grid, accept && req_type, state == S_GRID)
  `CFI_ASSERT_NEXT(a_div_holds, state == S_DIV && !st.div_done, state == S_DIV)

endmodule

@@ src/cfi_datapath.sv @@
// ----------------------------------------------------------------------------
// Contour flux integrator datapath
// Flux table memory, grid scaling, segment walk, divider, modulo, sampling
// and saturating accumulation, driven one operation per cycle.
// ----------------------------------------------------------------------------
module cfi_datapath #(
  parameter int TABLE_DEPTH = cfi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cfi_pkg::cfi_cmd_t                   cmd,
  output cfi_pkg::cfi_stat_t                  st,
  input  logic                                cfg_we,
  input  logic [cfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                req_type,
  input  logic [14:0]                         table_index,
  input  logic [cfi_pkg::TVAL_W-1:0]          table_value,
  input  logic [15:0]                         angle_phi,
  input  logic [14:0]                         angle_theta,
  input  logic                                last_point,
  output logic signed [cfi_pkg::FLUX_W-1:0]   flux,
  output logic                                flux_valid
);
  import cfi_pkg::*;

  localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MSTEPS_RAW  = $clog2(((2**ADDR_W) - 1) / TABLE_DEPTH + 1);
  localparam int MOD_STEPS   = (MSTEPS_RAW < 1) ? 1 : MSTEPS_RAW;
  localparam int MCNT_W      = $clog2(MOD_STEPS + 1);
  localparam int DSR_W       = ADDR_W + 1;
  localparam logic [DSR_W-1:0] DSR_INIT = DSR_W'(longint'(TABLE_DEPTH) << (MOD_STEPS - 1));
  localparam logic [AW:0]      DEPTH_V  = (AW + 1)'(TABLE_DEPTH);
  localparam logic [17:0]      DEPTH_18 = 18'(TABLE_DEPTH);

  // configuration
  logic [7:0] pc;
  logic [8:0] tc;
  logic [8:0] stride;

  // footpoint
  logic [15:0]        ang_phi;
  logic [14:0]        ang_theta;
  logic               last_pt;
  logic signed [31:0] pg, tg, prev_pg, prev_tg;
  logic               have_prev;

  // segment
  logic signed [31:0] phi1, phi2, th1, dth, dphi, cur, w;
  logic [9:0]         ip, np;
  logic [8:0]         col;
  logic               skip, lastp;
  logic signed [31:0] sweep;
  logic signed [FLUX_W-1:0] fsum;

  // divider
  logic signed [63:0] nprod;
  logic [REM_W-1:0]   rem, den;
  logic [DIV_QB-1:0]  nlow, quo;
  logic               qneg;
  logic [4:0]         dcnt;

  // addressing and sampling
  logic [9:0]           trow;
  logic [19:0]          fr;
  logic [ADDR_W-1:0]    r;
  logic [DSR_W-1:0]     dsr;
  logic [MCNT_W-1:0]    mcnt;
  logic [AW-1:0]        r1, raddr;
  logic [TVAL_W-1:0]    t0, t1, d, rdata;
  logic signed [61:0]   sprod;
  logic [59:0]          pa;
  logic [47:0]          pb;

  // finish
  logic [40:0] sw360;
  logic [31:0] swl;

  logic [TVAL_W-1:0] mem [TABLE_DEPTH];

  // combinational helpers
  logic signed [31:0] draw, half, full, dphi_c, edge_v, w_c, mid, mag_w, dmag;
  logic signed [32:0] ssum;
  logic               more;
  logic [9:0]         col_c;
  logic [63:0]        nmag;
  logic [REM_W-1:0]   trial;
  logic               ge;
  logic signed [29:0] qs;
  logic [18:0]        a_c;
  logic [AW:0]        rs;
  logic signed [40:0] sdiff;
  logic signed [61:0] ssum62;
  logic [48:0]        prod49;
  logic signed [49:0] nsum;
  logic [31:0]        sw;
  logic [7:0]         cv8;
  logic [8:0]         cv9;
  logic               small_sw, half_sw;
  logic signed [FLUX_W-1:0] f_c;

  assign stride = {1'b0, pc} + 9'd2;
  assign half   = $signed({5'b0, pc, 19'b0});
  assign full   = $signed({4'b0, pc, 20'b0});
  assign draw   = pg - prev_pg;
  assign dphi_c = phi2 - phi1;
  assign ssum   = {sweep[31], sweep} + {dphi_c[31], dphi_c};
  assign more   = (ip <= np);
  assign edge_v = $signed({2'b0, ip, 20'b0});
  assign w_c    = more ? (edge_v - cur) : (phi2 - cur);
  assign col_c  = (ip >= {1'b0, stride}) ? (ip - {2'b0, pc}) : ip;
  assign nmag   = nprod[63] ? 64'(-nprod) : 64'(nprod);
  assign dmag   = dphi[31] ? -dphi : dphi;
  assign trial  = {rem[REM_W-2:0], nlow[DIV_QB-1]};
  assign ge     = (trial >= den);
  assign qs     = qneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign mid    = th1 + {{2{qs[29]}}, qs};
  assign a_c    = trow * stride + {10'b0, col};
  assign rs     = (AW + 1)'(r) + (AW + 1)'(stride);
  assign sdiff  = $signed({1'b0, t1}) - $signed({1'b0, t0});
  assign ssum62 = $signed({22'b0, t0}) + (sprod >>> 20);
  assign mag_w  = w[31] ? -w : w;
  assign prod49 = {1'b0, pb} + {9'b0, pa[59:20]};
  assign nsum   = w[31] ? ({{2{fsum[47]}}, fsum} - $signed({1'b0, prod49}))
                        : ({{2{fsum[47]}}, fsum} + $signed({1'b0, prod49}));
  assign sw       = sweep[31] ? 32'(-sweep) : 32'(sweep);
  assign cv8      = cfg_data[7:0];
  assign cv9      = cfg_data[8:0];
  assign small_sw = sw360 < {13'b0, pc, 20'b0};
  assign half_sw  = swl < {5'b0, pc, 19'b0};
  assign raddr    = (cmd.op == OP_RD1) ? r1 : r[AW-1:0];

  // sign of the result from the total sweep
  always_comb begin
    f_c = fsum;
    if (half_sw) begin
      if (fsum > 0) f_c = -fsum;
    end else if (fsum < 0) begin
      f_c = (fsum == FLUX_MIN) ? FLUX_MAX : -fsum;
    end
  end

  assign st.have_prev  = have_prev;
  assign st.skip       = skip;
  assign st.last_piece = lastp;
  assign st.div_done   = (dcnt == 5'd1);
  assign st.mod_done   = (mcnt == MCNT_W'(1));
  assign st.last_pt    = last_pt;

  // table memory: load on item, registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TAKE && !req_type && ({3'b0, table_index} < DEPTH_18)) begin
      mem[AW'(table_index)] <= table_value;
    end
    rdata <= mem[raddr];
  end

  // configuration, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PHI_RESET;
      tc <= THETA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHI: begin
          pc <= (cv8 < PC_MIN) ? PC_MIN : ((cv8 > PC_MAX) ? PC_MAX : cv8);
        end
        CFG_THETA: begin
          tc <= (cv9 < TC_MIN) ? TC_MIN : ((cv9 > TC_MAX) ? TC_MAX : cv9);
        end
        default: ;
      endcase
    end
  end

  // contour state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pg   <= '0;
      prev_tg   <= '0;
      have_prev <= 1'b0;
      sweep     <= '0;
      fsum      <= '0;
    end else begin
      case (cmd.op)
        OP_SEG2: begin
          if (!skip) begin
            if (ssum > 33'sd2147483647) sweep <= 32'sh7FFFFFFF;
            else if (ssum < -33'sd2147483648) sweep <= 32'sh80000000;
            else sweep <= ssum[31:0];
          end
        end
        OP_ACC: begin
          if (nsum > $signed({{2{FLUX_MAX[47]}}, FLUX_MAX})) fsum <= FLUX_MAX;
          else if (nsum < $signed({{2{FLUX_MIN[47]}}, FLUX_MIN})) fsum <= FLUX_MIN;
          else fsum <= nsum[47:0];
        end
        OP_UPD: begin
          prev_pg   <= pg;
          prev_tg   <= tg;
          have_prev <= 1'b1;
        end
        OP_OUT: begin
          have_prev <= 1'b0;
          sweep     <= '0;
          fsum      <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE: begin
        ang_phi   <= angle_phi;
        ang_theta <= angle_theta;
        last_pt   <= last_point;
      end
      OP_GRID: begin
        pg <= $signed({4'b0, 24'(ang_phi) * 24'(pc), 4'b0});
        tg <= $signed({3'b0, 24'(ang_theta) * 24'(tc), 5'b0});
      end
      OP_SEG: begin
        skip <= (draw >= -32'sd1) && (draw <= 32'sd1);
        phi1 <= prev_pg + ((draw > half) ? full : 32'sd0);
        phi2 <= pg + ((draw < -half) ? full : 32'sd0);
        th1  <= prev_tg;
        dth  <= tg - prev_tg;
      end
      OP_SEG2: begin
        dphi <= dphi_c;
        ip   <= phi1[29:20] + 10'd1;
        np   <= phi2[29:20];
        cur  <= phi1;
      end
      OP_PIECE: begin
        w     <= w_c;
        col   <= col_c[8:0];
        lastp <= !more;
      end
      OP_MUL: begin
        nprod <= w * dth;
      end
      OP_DIVI: begin
        qneg <= nprod[63] ^ dphi[31];
        rem  <= nmag[DIV_QB+REM_W-1:DIV_QB];
        nlow <= nmag[DIV_QB-1:0];
        den  <= {dmag[REM_W-2:0], 1'b0};
        quo  <= '0;
        dcnt <= 5'(DIV_QB);
      end
      OP_DIV: begin
        rem  <= ge ? (trial - den) : trial;
        quo  <= {quo[DIV_QB-2:0], ge};
        nlow <= {nlow[DIV_QB-2:0], 1'b0};
        dcnt <= dcnt - 5'd1;
      end
      OP_MID: begin
        trow <= mid[31] ? 10'd0 : mid[29:20];
        fr   <= mid[31] ? 20'd0 : mid[19:0];
      end
      OP_ADDR: begin
        r    <= a_c;
        dsr  <= DSR_INIT;
        mcnt <= MCNT_W'(MOD_STEPS);
      end
      OP_MOD: begin
        if (DSR_W'(r) >= dsr) r <= r - dsr[ADDR_W-1:0];
        dsr  <= dsr >> 1;
        mcnt <= mcnt - MCNT_W'(1);
      end
      OP_RD0: begin
        r1 <= (rs >= DEPTH_V) ? AW'(rs - DEPTH_V) : AW'(rs);
      end
      OP_RD1: begin
        t0 <= rdata;
      end
      OP_RD2: begin
        t1 <= rdata;
      end
      OP_SAMP: begin
        sprod <= sdiff * $signed({1'b0, fr});
      end
      OP_SAMP2: begin
        d <= ssum62[TVAL_W-1:0];
      end
      OP_CON: begin
        pa <= d * mag_w[19:0];
        pb <= d * mag_w[27:20];
      end
      OP_ACC: begin
        if (!lastp) begin
          cur <= edge_v;
          ip  <= ip + 10'd1;
        end
      end
      OP_FIN: begin
        sw360 <= sw * 9'd360;
        swl   <= sw;
      end
      OP_OUT: begin
        flux       <= small_sw ? '0 : f_c;
        flux_valid <= !small_sw;
      end
      default: ;
    endcase
  end

endmodule

@@ src/contour_flux_integrator.sv @@
// ----------------------------------------------------------------------------
// Contour flux integrator
// Loads a cumulative flux table, then integrates flux along a contour of
// footpoints, walking each segment cell by cell in longitude.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_stall   req_type table_index table_value angle_phi
//                                 angle_theta last_point
//  res      res_valid/res_stall   flux flux_valid
//  cfg      cfg_valid/cfg_ready   cfg_index cfg_data
//
//  A table load is written in the idle state and never stalls requests. A
//  footpoint is scaled to the grid and, with a previous point, its segment is
//  walked in longitude pieces, each with modulo steps for the table address
//  and a 29-bit serial divide, its longest step. A last footpoint adds finish
//  and output, more while an earlier result stalls. rst clears the contour
//  state and registers; the table is undefined until loaded. A stalled
//  result is held while the next item is taken, and only the next waits for it.
// ----------------------------------------------------------------------------
module contour_flux_integrator #(
  parameter int TABLE_DEPTH = cfi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                req_type,
  input  logic [14:0]                         table_index,
  input  logic [cfi_pkg::TVAL_W-1:0]          table_value,
  input  logic [15:0]                         angle_phi,
  input  logic [14:0]                         angle_theta,
  input  logic                                last_point,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [cfi_pkg::FLUX_W-1:0]   flux,
  output logic                                flux_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cfi_pkg::*;

  cfi_cmd_t  cmd;
  cfi_stat_t st;

  // registers are always writable
  assign cfg_ready = 1'b1;

  cfi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .st        (st)
  );

  cfi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .table_index (table_index),
    .table_value (table_value),
    .angle_phi   (angle_phi),
    .angle_theta (angle_theta),
    .last_point  (last_point),
    .flux        (flux),
    .flux_valid  (flux_valid)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Contour flux integrator testbench
// Loads flux table regions, drives directed and random footpoint contours over
// several grid settings; checks each flux against a model or a fixed value.
// ----------------------------------------------------------------------------
module testbench;
  import cfi_pkg::*;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;
  localparam int TBL_DEPTH  = 32768;
  localparam longint FLUX_LIM  = 64'sd140737488355327;
  localparam longint SWEEP_LIM = 64'sd2147483647;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int N_DIRECTED = 23;

  typedef struct packed {
    logic signed [FLUX_W-1:0] flux;
    logic                     ok;
  } flux_res_t;

  typedef struct packed {
    logic                     kind;
    logic [14:0]              idx;
    logic [TVAL_W-1:0]        val;
    logic [15:0]              phi;
    logic [14:0]              th;
    logic                     last;
    logic                     fixed;
    logic signed [FLUX_W-1:0] xflux;
    logic                     xok;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic req_type = REQ_LOAD;
  logic [14:0] table_index = '0;
  logic [TVAL_W-1:0] table_value = '0;
  logic [15:0] angle_phi = '0;
  logic [14:0] angle_theta = '0;
  logic last_point = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [FLUX_W-1:0] flux;
  logic flux_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PHI;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  contour_flux_integrator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .table_index(table_index), .table_value(table_value), .angle_phi(angle_phi),
    .angle_theta(angle_theta), .last_point(last_point),
    .res_valid(res_valid), .res_stall(res_stall), .flux(flux), .flux_valid(flux_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // flux model state
  logic [TVAL_W-1:0] fm_table [0:TBL_DEPTH-1];
  logic [7:0] fm_pc_reg = PHI_RESET;
  logic [8:0] fm_tc_reg = THETA_RESET;
  longint fm_prev_phi = 0;
  longint fm_prev_theta = 0;
  bit fm_have_prev = 0;
  longint fm_flux = 0;
  longint fm_sweep = 0;

  flux_res_t flux_expected [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int items_sent = 0;

  function automatic longint pc_used();
    if (fm_pc_reg < 4) return 4;
    if (fm_pc_reg > 254) return 254;
    return fm_pc_reg;
  endfunction

  function automatic longint tc_used();
    if (fm_tc_reg < 4) return 4;
    if (fm_tc_reg > 510) return 510;
    return fm_tc_reg;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // interpolate between rows t and t+1 at the midpoint colatitude
  function automatic longint table_sample(longint col, longint mid);
    longint stride, t, fr, a0, a1;
    stride = pc_used() + 2;
    if (mid < 0) mid = 0;
    t = mid >>> 20;
    fr = mid & 64'hFFFFF;
    while (col >= stride) col -= pc_used();
    a0 = (t * stride + col) % TBL_DEPTH;
    a1 = ((t + 1) * stride + col) % TBL_DEPTH;
    return (64'(fm_table[a0]) * ((64'sd1 << 20) - fr) + 64'(fm_table[a1]) * fr) >>> 20;
  endfunction

  function automatic void add_strip(longint col, longint th1, longint dth, longint dphi,
                                    longint w);
    longint mid, d, mag, prod;
    mid = th1 + (dth * w) / (2 * dphi);
    d = table_sample(col, mid);
    mag = (w < 0) ? -w : w;
    prod = d * (mag >>> 20) + ((d * (mag & 64'hFFFFF)) >>> 20);
    fm_flux = clamp((w < 0) ? fm_flux - prod : fm_flux + prod, FLUX_LIM);
  endfunction

  // unwrap across the seam and walk the longitude cells crossed
  function automatic void walk_segment(longint phi1, longint th1, longint phi2, longint th2);
    longint half, dphi, dth, cur, ip, np;
    half = pc_used() << 19;
    dphi = phi2 - phi1;
    dth = th2 - th1;
    if (dphi >= -1 && dphi <= 1) return;
    if (dphi < -half) phi2 += 2 * half;
    else if (dphi > half) phi1 += 2 * half;
    dphi = phi2 - phi1;
    fm_sweep = clamp(fm_sweep + dphi, SWEEP_LIM);
    cur = phi1;
    ip = (cur >>> 20) + 1;
    np = phi2 >>> 20;
    while (ip <= np) begin
      add_strip(ip, th1, dth, dphi, (ip << 20) - cur);
      cur = ip << 20;
      ip++;
    end
    add_strip(ip, th1, dth, dphi, phi2 - cur);
  endfunction

  function automatic bit predict_point(logic [15:0] phi, logic [14:0] th, logic last,
                                       output flux_res_t res);
    longint pg, tg, sw, f;
    pg = 64'(phi) * pc_used() * 16;
    tg = 64'(th) * tc_used() * 32;
    res = '0;
    if (fm_have_prev) walk_segment(fm_prev_phi, fm_prev_theta, pg, tg);
    fm_prev_phi = pg;
    fm_prev_theta = tg;
    fm_have_prev = 1;
    if (!last) return 0;
    sw = (fm_sweep < 0) ? -fm_sweep : fm_sweep;
    f = fm_flux;
    if (sw * 360 >= (pc_used() << 20)) begin
      if (sw < (pc_used() << 19)) begin
        if (f > 0) f = -f;
      end else if (f < 0) begin
        f = (f == -FLUX_LIM - 1) ? FLUX_LIM : -f;
      end
      res.flux = f[FLUX_W-1:0];
      res.ok = 1'b1;
    end
    fm_have_prev = 0;
    fm_flux = 0;
    fm_sweep = 0;
    return 1;
  endfunction

  // drive one item, hold it until taken, then update the model
  task automatic send_item(logic kind, logic [14:0] idx, logic [TVAL_W-1:0] val,
                           logic [15:0] phi, logic [14:0] th, logic last,
                           logic fixed, flux_res_t fixed_res);
    flux_res_t res;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    table_index <= idx;
    table_value <= val;
    angle_phi <= phi;
    angle_theta <= th;
    last_point <= last;
    do @(posedge clk); while (req_stall);
    items_sent++;
    if (kind == REQ_LOAD) begin
      fm_table[idx] = val;
    end else if (predict_point(phi, th, last, res)) begin
      flux_expected.push_back(fixed ? fixed_res : res);
    end
  endtask

  task automatic send_point(logic [15:0] phi, logic [14:0] th, logic last);
    send_item(REQ_POINT, 15'($urandom), 40'({$urandom, $urandom}), phi, th, last, 1'b0, '0);
  endtask

  // pause until every expected flux has come, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    while (flux_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PHI) fm_pc_reg = data[7:0];
    else fm_tc_reg = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TVAL_W-1:0] rand_value();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // load rows 0..rows_used, every column the walk can reach
  task automatic load_rows(int rows_used);
    longint addr;
    for (int t = 0; t <= rows_used; t++) begin
      for (int c = 0; c < pc_used() + 2; c++) begin
        addr = (t * (pc_used() + 2) + c) % TBL_DEPTH;
        send_item(REQ_LOAD, 15'(addr), rand_value(), 16'($urandom), 15'($urandom),
                  1'($urandom), 1'b0, '0);
      end
    end
  endtask

  function automatic logic [14:0] rand_theta(int th_max);
    case ($urandom_range(9, 0))
      0: return 15'd0;
      1: return 15'(th_max);
      default: return 15'($urandom_range(th_max, 0));
    endcase
  endfunction

  // one random contour: full loops, partial arcs, tiny moves or noise
  task automatic send_contour(int th_max);
    int kind, n, step, dir, phi;
    kind = $urandom_range(9, 0);
    phi = $urandom_range(65535, 0);
    dir = $urandom_range(1, 0) ? 1 : -1;
    if (kind <= 4) begin
      n = $urandom_range(9, 3);
      step = 65536 / n;
    end else if (kind <= 6) begin
      n = $urandom_range(5, 1);
      step = $urandom_range(8000, 0);
    end else if (kind == 7) begin
      n = $urandom_range(3, 1);
      step = $urandom_range(60, 0);
    end else begin
      n = $urandom_range(5, 0);
      step = 0;
    end
    for (int i = 0; i <= n; i++) begin
      if (kind <= 7 && i != 0) begin
        phi = phi + dir * (step + (step > 8 ? $urandom_range(step / 8, 0) : 0));
      end else if (kind > 7) begin
        phi = $urandom_range(65535, 0);
      end
      // broken sequence: a stray load between footpoints
      if (kind == 9 || $urandom_range(19, 0) == 0) begin
        send_item(REQ_LOAD, 15'($urandom), rand_value(), 16'($urandom), 15'($urandom),
                  1'($urandom), 1'b0, '0);
      end
      send_point(16'(phi & 65535), rand_theta(th_max), i == n);
    end
  endtask

  task automatic run_phase(logic [8:0] pc_data, logic [8:0] tc_data, int rows_used,
                           int budget, int idle_pct, int stall_level);
    int th_max, start;
    drain();
    write_reg(CFG_PHI, pc_data);
    write_reg(CFG_THETA, tc_data);
    send_idle_pct = idle_pct;
    stall_pct = stall_level;
    load_rows(rows_used);
    th_max = (rows_used * 32768 - 1) / tc_used();
    if (th_max > 32767) th_max = 32767;
    start = items_sent;
    while (items_sent - start < budget) begin
      send_contour(th_max);
      if ($urandom_range(39, 0) == 0) drain();
    end
    drain();
  endtask

  // directed rows at phi_cells = theta_cells = 4 with rows 0..4 loaded
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_LOAD,  15'd0,     40'd0,  16'd0,     15'd0,     1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_LOAD,  15'd32767, '1,     16'd0,     15'd0,     1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_LOAD,  15'd5,     '1,     16'd0,     15'd0,     1'b0, 1'b0, 48'sd0, 1'b0},
    // single point: zero sweep
    '{REQ_POINT, 15'd0,     40'd0,  16'd0,     15'd0,     1'b1, 1'b1, 48'sd0, 1'b0},
    // zero step
    '{REQ_POINT, 15'd0,     40'd0,  16'd100,   15'd100,   1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd100,   15'd100,   1'b1, 1'b1, 48'sd0, 1'b0},
    // sweep under one degree
    '{REQ_POINT, 15'd0,     40'd0,  16'd0,     15'd16384, 1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd100,   15'd16384, 1'b1, 1'b1, 48'sd0, 1'b0},
    // partial arc under half a turn
    '{REQ_POINT, 15'd0,     40'd0,  16'd0,     15'd8000,  1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd20000, 15'd20000, 1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd30000, 15'd32767, 1'b1, 1'b0, 48'sd0, 1'b0},
    // full loop across the seam
    '{REQ_POINT, 15'd0,     40'd0,  16'd65535, 15'd0,     1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd16384, 15'd32767, 1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd32768, 15'd10000, 1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd49152, 15'd20000, 1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd65535, 15'd0,     1'b1, 1'b0, 48'sd0, 1'b0},
    // backward across the seam
    '{REQ_POINT, 15'd0,     40'd0,  16'd1000,  15'd5000,  1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd64000, 15'd3000,  1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd60000, 15'd100,   1'b1, 1'b0, 48'sd0, 1'b0},
    // long backward arc
    '{REQ_POINT, 15'd0,     40'd0,  16'd40000, 15'd2000,  1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd10000, 15'd30000, 1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd5000,  15'd1,     1'b0, 1'b0, 48'sd0, 1'b0},
    '{REQ_POINT, 15'd0,     40'd0,  16'd5000,  15'd32767, 1'b1, 1'b0, 48'sd0, 1'b0}
  };

  // check each flux taken against the oldest expectation
  initial begin
    flux_res_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (flux_expected.size() == 0) begin
          $display("%0t: unexpected flux result %0d valid %0b", $time, flux, flux_valid);
          fail_count++;
        end else begin
          want = flux_expected.pop_front();
          if (flux !== want.flux) begin
            $display("%0t: flux expected %0d actual %0d", $time, want.flux, flux);
            fail_count++;
          end
          if (flux_valid !== want.ok) begin
            $display("%0t: flux_valid expected %0b actual %0b", $time, want.ok, flux_valid);
            fail_count++;
          end
        end
      end
      res_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_PHI, 9'd4);
    write_reg(CFG_THETA, 9'd4);
    load_rows(4);
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      send_item(row.kind, row.idx, row.val, row.phi, row.th, row.last, row.fixed,
                '{flux: row.xflux, ok: row.xok});
    end

    run_phase(9'd4, 9'd4, 4, 80, 76, 0);
    run_phase(9'd72, 9'd360, 1, 60, 0, 76);
    run_phase(9'h100, 9'd3, 4, 50, 38, 38);
    run_phase(9'h1FF, 9'd511, 1, 20, 0, 0);
    run_phase(9'($urandom_range(20, 4)), 9'($urandom_range(510, 4)), 3, 50, 0, 76);
    run_phase(9'($urandom_range(20, 4)), 9'($urandom_range(510, 4)), 3, 40, 38, 38);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
